@@ rtl/tnms_pkg.sv @@
// shared constants and controller/datapath interface types for top-n max selection
`default_nettype none
package tnms_pkg;

    localparam int STORE_DEPTH_DEF  = 256;
    localparam int MAX_PICKS_DEF    = 16;
    localparam int SAMPLE_W         = 32;
    localparam int INDEX_W          = 8;
    localparam int PICK_CFG_W       = 5;
    localparam int APB_ADDR_W       = 3;
    localparam int APB_DATA_W       = 32;

    localparam logic [SAMPLE_W-1:0]   MOST_NEG         = 32'h8000_0000;
    localparam logic [PICK_CFG_W-1:0] PICK_COUNT_RESET = 5'd10;

    // register index, taken from paddr[2]
    localparam logic REG_PICK_COUNT = 1'b0;

    typedef struct packed {
        logic load_wr;     // store the accepted sample beat
        logic fill_clear;  // empty the store for the next run
        logic pick_start;  // latch the clamped pick count
        logic scan_start;  // restart the read counter
        logic rd_en;       // issue one store read
        logic put;         // emit the best entry and knock it out
    } cmd_t;

    typedef struct packed {
        logic picks_zero;
        logic issue_last;
        logic out_free;
        logic pick_last;
    } stat_t;

endpackage
`default_nettype wire

@@ rtl/tnms_ctrl.sv @@
// controller state machine for top-n max selection
`default_nettype none
module tnms_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    input  wire logic          s_tlast,
    output logic               s_tready,
    output tnms_pkg::cmd_t     cmd,
    input  wire tnms_pkg::stat_t stat
);

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_PUT   = 2'd3;

    logic [1:0] state_reg, state_next;

    assign s_tready = (state_reg == ST_LOAD);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_LOAD: begin
                if (s_tvalid) begin
                    cmd.load_wr = 1'b1;
                    if (s_tlast) begin
                        if (stat.picks_zero) begin
                            cmd.fill_clear = 1'b1;
                        end else begin
                            cmd.pick_start = 1'b1;
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                cmd.rd_en = 1'b1;
                if (stat.issue_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last read data is compared in this cycle
                state_next = ST_PUT;
            end
            ST_PUT: begin
                if (stat.out_free) begin
                    cmd.put = 1'b1;
                    if (stat.pick_last) begin
                        cmd.fill_clear = 1'b1;
                        state_next     = ST_LOAD;
                    end else begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/tnms_dp.sv @@
// datapath for top-n max selection: store, scan compare, pick counter, output register
`default_nettype none
module tnms_dp #(
    parameter int STORE_DEPTH = tnms_pkg::STORE_DEPTH_DEF,
    parameter int MAX_PICKS   = tnms_pkg::MAX_PICKS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire tnms_pkg::cmd_t                      cmd,
    output tnms_pkg::stat_t                          stat,
    input  wire logic [tnms_pkg::SAMPLE_W-1:0]       s_sample,
    input  wire logic                                cfg_we,
    input  wire logic [tnms_pkg::PICK_CFG_W-1:0]     cfg_wdata,
    output logic [tnms_pkg::PICK_CFG_W-1:0]          cfg_value,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [tnms_pkg::SAMPLE_W-1:0]            m_value,
    output logic [tnms_pkg::INDEX_W-1:0]             m_index,
    output logic                                     m_last
);

    localparam int IDX_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
    localparam int PK_W   = $clog2(MAX_PICKS + 1);
    localparam int CMP_W  = (PK_W > tnms_pkg::PICK_CFG_W) ? PK_W : tnms_pkg::PICK_CFG_W;

    logic [tnms_pkg::SAMPLE_W-1:0] mem [STORE_DEPTH];

    logic [tnms_pkg::PICK_CFG_W-1:0] pick_cfg_reg;
    logic [CNT_W-1:0]                fill_reg;
    logic [CNT_W-1:0]                rd_cnt_reg;
    logic [tnms_pkg::SAMPLE_W-1:0]   rd_data_reg;
    logic [IDX_W-1:0]                rd_idx_reg;
    logic                            rd_vld_reg;
    logic signed [tnms_pkg::SAMPLE_W-1:0] best_val_reg;
    logic [IDX_W-1:0]                best_idx_reg;
    logic [PK_W-1:0]                 picks_reg;
    logic [PK_W-1:0]                 pick_cnt_reg;
    logic                            m_valid_reg;
    logic [tnms_pkg::SAMPLE_W-1:0]   m_value_reg;
    logic [tnms_pkg::INDEX_W-1:0]    m_index_reg;
    logic                            m_last_reg;

    logic [CMP_W-1:0]                pick_ext;
    logic [PK_W-1:0]                 picks_clamped;
    logic                            mem_we;
    logic [IDX_W-1:0]                mem_waddr;
    logic [tnms_pkg::SAMPLE_W-1:0]   mem_wdata;
    logic                            take_new;
    logic [IDX_W+tnms_pkg::INDEX_W-1:0] idx_ext;

    assign pick_ext      = CMP_W'(pick_cfg_reg);
    assign picks_clamped = (pick_ext > CMP_W'(MAX_PICKS)) ? PK_W'(MAX_PICKS)
                                                          : PK_W'(pick_ext);

    assign stat.picks_zero = (pick_cfg_reg == '0);
    assign stat.issue_last = (rd_cnt_reg == fill_reg - CNT_W'(1));
    assign stat.out_free   = !m_valid_reg || m_ready;
    assign stat.pick_last  = (pick_cnt_reg == picks_reg - PK_W'(1));

    // store write port: sample load or knock-out of the picked entry
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = fill_reg[IDX_W-1:0];
        mem_wdata = s_sample;
        if (cmd.put) begin
            mem_we    = 1'b1;
            mem_waddr = best_idx_reg;
            mem_wdata = tnms_pkg::MOST_NEG;
        end else if (cmd.load_wr && (fill_reg < CNT_W'(STORE_DEPTH))) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_cnt_reg[IDX_W-1:0]];
        end
    end

    // first entry seeds the best, later ones replace it only when strictly larger
    assign take_new = rd_vld_reg &&
                      ((rd_idx_reg == '0) || ($signed(rd_data_reg) > best_val_reg));

    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_cnt_reg[IDX_W-1:0];
        if (take_new) begin
            best_val_reg <= $signed(rd_data_reg);
            best_idx_reg <= rd_idx_reg;
        end
        if (cmd.pick_start) begin
            picks_reg <= picks_clamped;
        end
        if (cmd.put) begin
            m_value_reg <= best_val_reg;
            m_index_reg <= idx_ext[tnms_pkg::INDEX_W-1:0];
            m_last_reg  <= stat.pick_last;
        end
    end

    assign idx_ext = {{tnms_pkg::INDEX_W{1'b0}}, best_idx_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pick_cfg_reg <= tnms_pkg::PICK_COUNT_RESET;
            fill_reg     <= '0;
            rd_cnt_reg   <= '0;
            rd_vld_reg   <= 1'b0;
            pick_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                pick_cfg_reg <= cfg_wdata;
            end
            if (cmd.fill_clear) begin
                fill_reg <= '0;
            end else if (cmd.load_wr && (fill_reg < CNT_W'(STORE_DEPTH))) begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            if (cmd.scan_start) begin
                rd_cnt_reg <= '0;
            end else if (cmd.rd_en) begin
                rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
            end
            rd_vld_reg <= cmd.rd_en;
            if (cmd.pick_start) begin
                pick_cnt_reg <= '0;
            end else if (cmd.put) begin
                pick_cnt_reg <= pick_cnt_reg + PK_W'(1);
            end
            if (cmd.put) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign cfg_value = pick_cfg_reg;
    assign m_valid   = m_valid_reg;
    assign m_value   = m_value_reg;
    assign m_index   = m_index_reg;
    assign m_last    = m_last_reg;

endmodule
`default_nettype wire

@@ rtl/top_n_max_selection_top.sv @@
// top level of top-n max selection: stream ports, apb register port, controller and datapath
//
// Input stream s_*: one sample per beat in s_tdata, s_tlast marks the final
// sample of a run. Samples beyond STORE_DEPTH are dropped; the flag on a
// dropped beat still starts selection. Loading accepts one beat per cycle.
// After the final beat the block makes min(pick_count, MAX_PICKS) picks.
// Each pick is one full read scan of the N loaded entries through the single
// store read port, then a drain state that compares the last read data and an
// emit state that puts the result out and knocks the entry out of the store.
// Output stream m_*: one beat per pick, largest remaining value first, lowest
// index on ties; m_tlast on the last pick. A pick count of zero gives no beats.
// The result sits in an output register: the next scan runs while it waits;
// a stalled receiver holds the block at the next emit.
// APB port: register pick_count at byte address 0, written in the access
// phase, pready always high. Reset clears the run, the output and sets
// pick_count to 10; the store contents are not cleared.
`default_nettype none
module top_n_max_selection_top #(
    parameter int STORE_DEPTH = tnms_pkg::STORE_DEPTH_DEF,
    parameter int MAX_PICKS   = tnms_pkg::MAX_PICKS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [31:0]                         s_tdata,  // sample_value
    input  wire logic                                s_tlast,  // final_sample
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [39:0]                              m_tdata,  // picked_value, picked_index
    output logic                                     m_tlast,  // last_pick
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [tnms_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [tnms_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tnms_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                     pready
);

    tnms_pkg::cmd_t  cmd;
    tnms_pkg::stat_t stat;

    logic                              cfg_we;
    logic [tnms_pkg::PICK_CFG_W-1:0]   cfg_value;
    logic [tnms_pkg::SAMPLE_W-1:0]     m_value;
    logic [tnms_pkg::INDEX_W-1:0]      m_index;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready &&
                    (paddr[2] == tnms_pkg::REG_PICK_COUNT);
    assign prdata = (paddr[2] == tnms_pkg::REG_PICK_COUNT)
                    ? tnms_pkg::APB_DATA_W'(cfg_value) : '0;

    assign m_tdata = {m_index, m_value};

    tnms_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    tnms_dp #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_PICKS   (MAX_PICKS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_sample  (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (pwdata[tnms_pkg::PICK_CFG_W-1:0]),
        .cfg_value (cfg_value),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_value   (m_value),
        .m_index   (m_index),
        .m_last    (m_tlast)
    );

endmodule
`default_nettype wire

@@ sim/tb_top_n_max_selection_top.sv @@
// self-checking testbench for top-n max selection: stream runs, apb pick count, pick scoreboard
`timescale 1ns / 100ps
module tb_top_n_max_selection_top;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int END_CYCLES     = 300;
    localparam int PHASE_ITEMS    = 40;

    localparam logic [tnms_pkg::APB_ADDR_W-1:0] ADDR_PICK_COUNT =
        {tnms_pkg::REG_PICK_COUNT, 2'b00};
    localparam logic [tnms_pkg::APB_ADDR_W-1:0] ADDR_UNMAPPED   =
        {~tnms_pkg::REG_PICK_COUNT, 2'b00};

    typedef struct packed {
        logic [tnms_pkg::SAMPLE_W-1:0] value;
        logic [tnms_pkg::INDEX_W-1:0]  index;
        logic                          last;
    } pick_t;

    class pick_tracker;
        logic signed [tnms_pkg::SAMPLE_W-1:0] sample_store [tnms_pkg::STORE_DEPTH_DEF];
        int    loaded;
        int    pick_limit;
        int    errors;
        pick_t expected_picks [$];

        function new();
            loaded     = 0;
            pick_limit = tnms_pkg::PICK_COUNT_RESET;
            errors     = 0;
        endfunction

        function void set_pick_count(logic [tnms_pkg::APB_DATA_W-1:0] wdata);
            pick_limit = wdata[tnms_pkg::PICK_CFG_W-1:0];
        endfunction

        // append one sample; a final beat runs all picks of the run
        function void load_sample(logic [tnms_pkg::SAMPLE_W-1:0] sample, logic final_flag);
            int    picks;
            int    best;
            pick_t p;
            if (loaded < tnms_pkg::STORE_DEPTH_DEF) begin
                sample_store[loaded] = sample;
                loaded++;
            end
            if (!final_flag)
                return;
            picks = (pick_limit > tnms_pkg::MAX_PICKS_DEF) ? tnms_pkg::MAX_PICKS_DEF
                                                           : pick_limit;
            for (int k = 0; k < picks; k++) begin
                best    = 0;
                p.value = tnms_pkg::MOST_NEG;
                if (loaded > 0) begin
                    // strict greater keeps the lowest index on ties
                    for (int i = 1; i < loaded; i++)
                        if (sample_store[i] > sample_store[best])
                            best = i;
                    p.value = sample_store[best];
                    sample_store[best] = tnms_pkg::MOST_NEG;
                end
                p.index = best[tnms_pkg::INDEX_W-1:0];
                p.last  = (k == picks - 1);
                expected_picks.push_back(p);
            end
            loaded = 0;
        endfunction

        function void note_error(string what, pick_t want, pick_t got);
            errors++;
            if (errors <= 10)
                $display({"%s: expected value %0d index %0d last %0b,",
                          " got value %0d index %0d last %0b"},
                         what, $signed(want.value), want.index, want.last,
                         $signed(got.value), got.index, got.last);
        endfunction

        function void check_pick(pick_t got);
            pick_t want;
            if (expected_picks.size() == 0) begin
                note_error("pick beat with nothing pending", '0, got);
                return;
            end
            want = expected_picks.pop_front();
            if (got.value !== want.value || got.index !== want.index
                || got.last !== want.last)
                note_error("pick mismatch", want, got);
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    wire logic             s_tready;
    logic [31:0]           s_tdata;   // sample_value
    logic                  s_tlast;   // final_sample
    wire logic             m_tvalid;
    logic                  m_tready = 1'b0;
    wire logic [39:0]      m_tdata;   // picked_value, picked_index
    wire logic             m_tlast;   // last_pick
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [tnms_pkg::APB_ADDR_W-1:0] paddr;
    logic [tnms_pkg::APB_DATA_W-1:0] pwdata;
    wire logic [tnms_pkg::APB_DATA_W-1:0] prdata;
    wire logic             pready;

    pick_tracker tracker;
    int send_gap_pct;
    int recv_stall_pct;
    int idle_cycles;

    top_n_max_selection_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // result side: check each accepted beat, then pick the next ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                tracker.check_pick('{value: m_tdata[31:0], index: m_tdata[39:32],
                                     last: m_tlast});
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn)
            idle_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("FAIL top_n_max_selection_top");
        $finish;
    end

    // caller makes exactly one assignment to s_tvalid in the step this returns
    task automatic send_sample(input logic [31:0] sample, input logic last);
        if ($urandom_range(0, 99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        tracker.load_sample(sample, last);
    endtask

    function automatic logic [31:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return tnms_pkg::MOST_NEG;
            2, 3, 4: return 32'($urandom_range(0, 7)) - 32'd4;  // narrow range forces ties
            default: return $urandom();
        endcase
    endfunction

    task automatic send_run(input int len);
        for (int i = 0; i < len; i++)
            send_sample(random_sample(), i == len - 1);
    endtask

    task automatic drain_results(input int settle);
        s_tvalid <= 1'b0;
        while (tracker.expected_picks.size() != 0)
            @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [tnms_pkg::APB_ADDR_W-1:0] addr,
                             input logic [tnms_pkg::APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_PICK_COUNT)
            tracker.set_pick_count(data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // upper bits of pwdata are random, only the low field counts
    task automatic set_pick_count(input logic [tnms_pkg::PICK_CFG_W-1:0] picks);
        logic [tnms_pkg::APB_DATA_W-1:0] data;
        data = $urandom();
        data[tnms_pkg::PICK_CFG_W-1:0] = picks;
        drain_results(SETTLE_CYCLES);
        apb_write(ADDR_PICK_COUNT, data);
    endtask

    function automatic logic [tnms_pkg::PICK_CFG_W-1:0] random_pick_count();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 5'd1;
            2:       return 5'(tnms_pkg::MAX_PICKS_DEF);
            3:       return '1;
            default: return 5'($urandom_range(0, 31));
        endcase
    endfunction

    initial begin
        int len;
        int phase_items;
        tracker        = new();
        send_gap_pct   = 26;
        recv_stall_pct = 49;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset pick count of 10 against 7 samples: extremes, duplicate max, minimum loaded
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(tnms_pkg::MOST_NEG, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'h0000_0001, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(tnms_pkg::MOST_NEG, 1'b1);
        send_sample(32'h5555_5555, 1'b1);

        // zero picks: run yields nothing but still empties the store
        set_pick_count('0);
        send_sample(32'hAAAA_AAAA, 1'b0);
        send_sample(32'hFFFF_FFFB, 1'b0);
        send_sample(32'h0000_0007, 1'b1);

        // write to the unmapped index must leave zero picks in place
        drain_results(SETTLE_CYCLES);
        apb_write(ADDR_UNMAPPED, 32'h0000_0003);
        send_sample(32'h0000_0010, 1'b0);
        send_sample(32'h0000_0020, 1'b1);

        // pick count above the maximum clamps, ties go to the lowest index
        set_pick_count('1);
        send_sample(32'h0000_0003, 1'b0);
        send_sample(32'h0000_0003, 1'b0);
        send_sample(32'hFFFF_FFFE, 1'b0);
        send_sample(32'h0000_0003, 1'b0);
        send_sample(32'hFFFF_FFFE, 1'b1);

        set_pick_count(5'd1);
        send_sample(tnms_pkg::MOST_NEG, 1'b0);
        send_sample(tnms_pkg::MOST_NEG, 1'b1);

        for (int phase = 0; phase < 3; phase++) begin
            drain_results(SETTLE_CYCLES);
            case (phase)
                0: begin send_gap_pct = 26; recv_stall_pct = 49; end
                1: begin send_gap_pct = 49; recv_stall_pct = 26; end
                default: begin send_gap_pct = 0; recv_stall_pct = 0; end
            endcase
            set_pick_count(random_pick_count());
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                if ($urandom_range(0, 3) == 0)
                    set_pick_count(random_pick_count());
                else if ($urandom_range(0, 6) == 0)
                    drain_results(0);
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 30)
                                                  : $urandom_range(1, 8);
                send_run(len);
                phase_items += len;
            end
            if (phase == 2) begin
                // overfill the store: extra beats dropped, final flag lands on a dropped beat
                set_pick_count(5'(tnms_pkg::MAX_PICKS_DEF));
                send_run(tnms_pkg::STORE_DEPTH_DEF + $urandom_range(1, 6));
            end
        end

        drain_results(END_CYCLES);
        if (tracker.errors == 0 && tracker.expected_picks.size() == 0)
            $display("PASS top_n_max_selection_top");
        else
            $display("FAIL top_n_max_selection_top");
        $finish;
    end

endmodule
